// File: rtl/core/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// File: rtl/core/wfq_pkg.sv
// Package with shared constants and types for the finish tag stamper.
package wfq_pkg;
    localparam int FLOWS_DEF = 64;
    localparam logic [15:0] ONE_WEIGHT = 16'd256;
    localparam logic [47:0] FT_MAX = 48'hFFFF_FFFF_FFFF;
    localparam int KEY_W = 96;

    typedef struct packed {
        logic       load;
        logic       cmp;
        logic       create;
        logic       div_start;
        logic       update;
    } wfq_cmd_t;

    typedef struct packed {
        logic       match;
        logic       scan_last;
        logic       full;
        logic       div_done;
    } wfq_stat_t;
endpackage

// File: rtl/core/wfq_ram.sv
// Generic single-port RAM with registered read.
module wfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// File: rtl/core/wfq_ctrl.sv
// Controller state machine: scan, create, divide, update, emit.
module wfq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_fire,
    input  logic               out_fire,
    input  wfq_pkg::wfq_stat_t stat,
    output wfq_pkg::wfq_cmd_t  cmd,
    output logic               busy,
    output logic               out_valid
);
    import wfq_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_READ, S_CMP, S_DIV, S_UPD, S_OUT} state_t;
    state_t state_reg;
    logic   out_valid_reg;

    always_comb
    begin
        cmd = '0;
        cmd.load = in_fire;
        unique case (state_reg)
            S_CMP:
            begin
                cmd.cmp = 1'b1;
                if (!stat.match && stat.scan_last && !stat.full)
                begin
                    cmd.create = 1'b1;
                end
                if (stat.match || (stat.scan_last && !stat.full))
                begin
                    cmd.div_start = 1'b1;
                end
            end
            S_UPD: cmd.update = 1'b1;
            default: ;
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE: if (in_fire) state_reg <= S_READ;
                S_READ: state_reg <= S_CMP;
                S_CMP:
                begin
                    if (stat.match || (stat.scan_last && !stat.full))
                    begin
                        state_reg <= S_DIV;
                    end
                    else if (stat.scan_last)
                    begin
                        state_reg <= S_OUT;
                        out_valid_reg <= 1'b1;
                    end
                    else
                    begin
                        state_reg <= S_READ;
                    end
                end
                S_DIV: if (stat.div_done) state_reg <= S_UPD;
                S_UPD:
                begin
                    state_reg <= S_OUT;
                    out_valid_reg <= 1'b1;
                end
                S_OUT:
                begin
                    if (out_fire)
                    begin
                        state_reg <= S_IDLE;
                        out_valid_reg <= 1'b0;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// File: rtl/core/wfq_dp.sv
// Datapath: flow table, lookup, restoring divider and finish time update.
module wfq_dp #(
    parameter int FLOWS = wfq_pkg::FLOWS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  wfq_pkg::wfq_cmd_t cmd,
    input  logic [159:0]      in_data,
    output wfq_pkg::wfq_stat_t stat,
    output logic [71:0]       out_data,
    output logic              out_full
);
    import wfq_pkg::*;

    localparam int IW = $clog2(FLOWS);
    localparam int CW = $clog2(FLOWS + 1);
    localparam int EW = KEY_W + 16 + 48;

    logic [31:0]  arr_reg;
    logic [KEY_W-1:0] key_reg;
    logic [15:0]  len_reg, w_reg;
    logic [IW-1:0] idx_reg;
    logic [CW-1:0] used_reg;
    logic [FLOWS-1:0] valid_reg;
    logic         full_reg;
    logic [15:0]  wu_reg;
    logic [47:0]  last_reg, fin_reg;
    logic [31:0]  q_reg;
    logic [16:0]  rem_reg;
    logic [5:0]   cnt_reg;
    logic         div_on_reg;

    logic         we;
    logic [EW-1:0] wdata, rdata;
    logic [IW-1:0] addr;
    logic [15:0]  w_sel;
    logic [47:0]  start, q_ext;
    logic [48:0]  sum;
    logic [16:0]  rem_sh;

    assign addr = cmd.create ? used_reg[IW-1:0] : idx_reg;
    assign we = cmd.update;
    assign wdata = {key_reg, wu_reg, fin_reg};

    wfq_ram #(.WIDTH(EW), .DEPTH(FLOWS)) u_ram (
        .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    assign stat.match = valid_reg[idx_reg] && (rdata[EW-1 -: KEY_W] == key_reg);
    assign stat.scan_last = (idx_reg == IW'(FLOWS - 1)) || ({1'b0, idx_reg} + 1'b1 >= used_reg);
    assign stat.full = (used_reg == CW'(FLOWS));
    assign stat.div_done = div_on_reg && (cnt_reg == 6'd0);

    // Weight selection: 1.0 keeps a stored weight that is not 1.0.
    assign w_sel = (stat.match && w_reg == ONE_WEIGHT) ? rdata[63:48] : w_reg;

    assign rem_sh = {rem_reg[15:0], (cnt_reg > 6'd16) ? len_reg[4'(cnt_reg - 6'd17)] : 1'b0};
    assign start = (last_reg > {8'd0, arr_reg, 8'd0}) ? last_reg : {8'd0, arr_reg, 8'd0};
    assign q_ext = (wu_reg == 16'd0) ? FT_MAX : {16'd0, q_reg};
    assign sum = {1'b0, start} + {1'b0, q_ext};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            valid_reg <= '0;
            div_on_reg <= 1'b0;
            full_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                full_reg <= 1'b0;
            end
            if (cmd.cmp && !stat.match && stat.scan_last && stat.full)
            begin
                full_reg <= 1'b1;
            end
            if (cmd.create)
            begin
                used_reg <= used_reg + 1'b1;
                valid_reg[used_reg[IW-1:0]] <= 1'b1;
            end
            if (cmd.div_start)
            begin
                div_on_reg <= 1'b1;
            end
            else if (stat.div_done)
            begin
                div_on_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            arr_reg <= in_data[31:0];
            key_reg <= {in_data[63:32], in_data[79:64], in_data[111:80], in_data[127:112]};
            len_reg <= in_data[143:128];
            w_reg   <= in_data[159:144];
            idx_reg <= '0;
        end
        else if (cmd.cmp && !stat.match && !stat.scan_last)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.div_start)
        begin
            if (cmd.create) idx_reg <= used_reg[IW-1:0];
            wu_reg   <= cmd.create ? w_reg : w_sel;
            last_reg <= cmd.create ? 48'd0 : rdata[47:0];
            rem_reg  <= '0;
            q_reg    <= '0;
            cnt_reg  <= 6'd32;
        end
        else if (div_on_reg && cnt_reg != 6'd0)
        begin
            if (rem_sh >= {1'b0, wu_reg})
            begin
                rem_reg <= rem_sh - {1'b0, wu_reg};
                q_reg   <= {q_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                q_reg   <= {q_reg[30:0], 1'b0};
            end
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (stat.div_done)
        begin
            fin_reg <= sum[48] ? FT_MAX : sum[47:0];
        end
    end

    assign out_full = full_reg;
    assign out_data = full_reg ? 72'd0 :
        {1'b0, (w_reg != ONE_WEIGHT), wu_reg, fin_reg, 6'(idx_reg)};
endmodule

// File: rtl/core/wfq_finish_tag_stamper.sv
// Top level of the weighted fair queuing finish tag stamper.
//  channel | direction | content
//  s_axis  | in        | one packet descriptor per beat
//  m_axis  | out       | one stamp per beat, tuser = table full
// One packet reads and then compares each scanned flow entry in turn, then
// runs a restoring division (one quotient bit a cycle) and an update step.
// Reset clears the valid bits and flow count; no clearing pass is needed.
// The result waits in the output register while m_axis_tready is low; no
// new packet is taken until it leaves.
`include "assert_macros.svh"
module wfq_finish_tag_stamper #(
    parameter int FLOWS = wfq_pkg::FLOWS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // arrival_time, src_addr, src_port, dst_addr, dst_port, pkt_length, pkt_weight
    input  logic [159:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // flow_index, finish_time, weight_used, weight_explicit, zero fill
    output logic [71:0]  m_axis_tdata,
    // table_full
    output logic         m_axis_tuser
);
    import wfq_pkg::*;

    wfq_cmd_t  cmd;
    wfq_stat_t stat;
    logic      busy, in_fire, out_fire;

    assign s_axis_tready = !busy;
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    wfq_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_fire(out_fire),
        .stat(stat), .cmd(cmd), .busy(busy), .out_valid(m_axis_tvalid)
    );

    // The datapath keys the table by source address, source port,
    // destination address and destination port as they come in the beat.
    wfq_dp #(.FLOWS(FLOWS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_data(s_axis_tdata),
        .stat(stat), .out_data(m_axis_tdata), .out_full(m_axis_tuser)
    );

    `ASSERT_IMPL(a_no_accept_busy, clk, rst_n, m_axis_tvalid |-> !s_axis_tready)
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, in_fire, busy)
    `ASSERT_IMPL(a_full_zero, clk, rst_n, (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 72'd0))
endmodule

// File: dv/wfq_finish_tag_stamper_tb.sv
// Self-checking testbench for the weighted fair queuing finish tag stamper.
module wfq_finish_tag_stamper_tb;
    import wfq_pkg::*;

    localparam int NFLOWS = 64;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int POOL_SIZE = 48;

    // One packet descriptor, last field in the lowest bits of tdata.
    typedef struct packed {
        logic [15:0] pkt_weight;
        logic [15:0] pkt_length;
        logic [15:0] dst_port;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [31:0] src_addr;
        logic [31:0] arrival_time;
    } pkt_t;

    // One stamp as carried on tdata plus the table-full flag from tuser.
    typedef struct {
        logic [5:0]  flow_index;
        logic [47:0] finish_time;
        logic [15:0] weight_used;
        logic        weight_explicit;
        logic        table_full;
    } stamp_t;

    typedef struct {
        logic [31:0] src_addr;
        logic [15:0] src_port;
        logic [31:0] dst_addr;
        logic [15:0] dst_port;
    } flow_key_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // arrival_time, src_addr, src_port, dst_addr, dst_port, pkt_length, pkt_weight
    logic [159:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // flow_index, finish_time, weight_used, weight_explicit, zero fill
    logic [71:0]  m_axis_tdata;
    // table_full
    logic         m_axis_tuser;

    wfq_finish_tag_stamper uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Shadow flow table used to predict every stamp.
    logic        flow_valid [NFLOWS];
    flow_key_t   flow_key [NFLOWS];
    logic [15:0] flow_weight [NFLOWS];
    logic [47:0] flow_last_finish [NFLOWS];
    int          flow_count;

    stamp_t      pending_stamps[$];
    flow_key_t   key_pool [POOL_SIZE];

    int  send_idle_pct;
    int  recv_stall_pct;
    int  idle_cycles;
    bit  failed;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Works out the stamp for one accepted packet and updates the shadow table.
    function automatic stamp_t stamp_packet(input pkt_t p);
        stamp_t      s;
        int          slot;
        bit          hit;
        logic [63:0] start_t;
        logic [63:0] incr;
        logic [63:0] fin;
        slot = 0;
        hit = 0;
        for (int i = 0; i < NFLOWS; i++)
        begin
            if (!hit && flow_valid[i] && flow_key[i].src_addr == p.src_addr &&
                flow_key[i].src_port == p.src_port && flow_key[i].dst_addr == p.dst_addr &&
                flow_key[i].dst_port == p.dst_port)
            begin
                slot = i;
                hit = 1;
            end
        end
        if (!hit)
        begin
            if (flow_count >= NFLOWS)
            begin
                s.flow_index = '0;
                s.finish_time = '0;
                s.weight_used = '0;
                s.weight_explicit = 1'b0;
                s.table_full = 1'b1;
                return s;
            end
            slot = flow_count;
            flow_count++;
            flow_valid[slot] = 1'b1;
            flow_key[slot].src_addr = p.src_addr;
            flow_key[slot].src_port = p.src_port;
            flow_key[slot].dst_addr = p.dst_addr;
            flow_key[slot].dst_port = p.dst_port;
            flow_weight[slot] = p.pkt_weight;
            flow_last_finish[slot] = '0;
        end
        // A weight of exactly 1.0 keeps a stored weight other than 1.0.
        if (!(p.pkt_weight == ONE_WEIGHT && flow_weight[slot] != ONE_WEIGHT))
            flow_weight[slot] = p.pkt_weight;
        start_t = {24'd0, p.arrival_time, 8'd0};
        if ({16'd0, flow_last_finish[slot]} > start_t)
            start_t = {16'd0, flow_last_finish[slot]};
        if (flow_weight[slot] == 16'd0)
            incr = {16'd0, FT_MAX};
        else
            incr = {32'd0, p.pkt_length, 16'd0} / {48'd0, flow_weight[slot]};
        fin = start_t + incr;
        if (fin > {16'd0, FT_MAX})
            fin = {16'd0, FT_MAX};
        flow_last_finish[slot] = fin[47:0];
        s.flow_index = slot[5:0];
        s.finish_time = fin[47:0];
        s.weight_used = flow_weight[slot];
        s.weight_explicit = (p.pkt_weight != ONE_WEIGHT);
        s.table_full = 1'b0;
        return s;
    endfunction

    // Sends one beat; returns at the falling edge after acceptance with tvalid
    // still high so a following beat can be offered without first dropping tvalid.
    task automatic send_pkt(input pkt_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= p;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_stamps.push_back(stamp_packet(p));
        @(negedge clk);
    endtask

    task automatic drain_stamps();
        s_axis_tvalid <= 1'b0;
        while (pending_stamps.size() != 0)
            @(negedge clk);
    endtask

    function automatic pkt_t make_pkt(input flow_key_t k, input logic [31:0] arr,
                                      input logic [15:0] len, input logic [15:0] w);
        pkt_t p;
        p.src_addr = k.src_addr;
        p.src_port = k.src_port;
        p.dst_addr = k.dst_addr;
        p.dst_port = k.dst_port;
        p.arrival_time = arr;
        p.pkt_length = len;
        p.pkt_weight = w;
        return p;
    endfunction

    function automatic flow_key_t fresh_key();
        flow_key_t k;
        k.src_addr = $urandom;
        k.src_port = $urandom;
        k.dst_addr = $urandom;
        k.dst_port = $urandom;
        return k;
    endfunction

    task automatic test_directed();
        flow_key_t a;
        flow_key_t ones;
        flow_key_t zeros;
        flow_key_t zw;
        a = fresh_key();
        ones = '{32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF};
        zeros = '{32'd0, 16'd0, 32'd0, 16'd0};
        zw = fresh_key();
        // New flow with the default weight, then an explicit weight that
        // sticks, then default weight that must keep the stored one.
        send_pkt(make_pkt(a, 32'd10, 16'd1000, ONE_WEIGHT));
        send_pkt(make_pkt(a, 32'd11, 16'd1000, 16'd512));
        send_pkt(make_pkt(a, 32'd0, 16'd1000, ONE_WEIGHT));
        send_pkt(make_pkt(a, 32'd0, 16'd0, 16'd65535));
        send_pkt(make_pkt(a, 32'hFFFF_FFFF, 16'd65535, 16'd1));
        send_pkt(make_pkt(a, 32'd5, 16'd65535, 16'd1));
        // Keys at both extremes and keys that differ in one field only.
        send_pkt(make_pkt(ones, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
        send_pkt(make_pkt(zeros, 32'd0, 16'd0, 16'd1));
        send_pkt(make_pkt('{32'd0, 16'd0, 32'd0, 16'd1}, 32'd1, 16'd1, ONE_WEIGHT));
        send_pkt(make_pkt('{32'd0, 16'd1, 32'd0, 16'd0}, 32'd1, 16'd1, ONE_WEIGHT));
        send_pkt(make_pkt('{32'd1, 16'd0, 32'd0, 16'd0}, 32'd1, 16'd1, ONE_WEIGHT));
        send_pkt(make_pkt('{32'd0, 16'd0, 32'd1, 16'd0}, 32'd1, 16'd1, ONE_WEIGHT));
        send_pkt(make_pkt(zeros, 32'd2, 16'd300, 16'd255));
        send_pkt(make_pkt(ones, 32'd0, 16'd777, 16'd257));
        // A zero weight drives the finish time to saturation and is kept.
        send_pkt(make_pkt(zw, 32'd3, 16'd10, 16'd0));
        send_pkt(make_pkt(zw, 32'd4, 16'd10, ONE_WEIGHT));
        send_pkt(make_pkt(zw, 32'd4, 16'd10, 16'd128));
    endtask

    task automatic test_random(input int n, input int idle_pct, input int stall_pct);
        flow_key_t k;
        logic [31:0] arr;
        logic [15:0] len;
        logic [15:0] w;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 8)
                k = fresh_key();
            else
                k = key_pool[$urandom_range(POOL_SIZE - 1)];
            arr = ($urandom_range(1) == 0) ? $urandom : $urandom_range(4000);
            len = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1500));
            case ($urandom_range(4))
                0, 1: w = ONE_WEIGHT;
                2: w = 16'($urandom_range(1, 1024));
                default: w = 16'($urandom_range(1, 65535));
            endcase
            send_pkt(make_pkt(k, arr, len, w));
        end
    endtask

    // Fresh keys until the table overflows, then hits on stored flows.
    task automatic test_table_full();
        for (int i = 0; i < NFLOWS + 4; i++)
            send_pkt(make_pkt(fresh_key(), $urandom, 16'($urandom), 16'($urandom_range(1, 65535))));
        for (int i = 0; i < 10; i++)
            send_pkt(make_pkt(flow_key[$urandom_range(NFLOWS - 1)], $urandom, 16'($urandom),
                              ONE_WEIGHT));
    endtask

    // Receiver stalls are drawn fresh on every falling edge.
    always @(negedge clk)
    begin
        if (rst_n)
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Result checker and watchdog.
    always @(posedge clk)
    begin
        stamp_t e;
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_stamps.size() == 0)
                begin
                    $error("stamp beat with no packet outstanding");
                    failed = 1'b1;
                end
                else
                begin
                    e = pending_stamps.pop_front();
                    if (m_axis_tdata[5:0] !== e.flow_index)
                    begin
                        $error("flow_index exp %0d got %0d", e.flow_index, m_axis_tdata[5:0]);
                        failed = 1'b1;
                    end
                    if (m_axis_tdata[53:6] !== e.finish_time)
                    begin
                        $error("finish_time exp %h got %h", e.finish_time, m_axis_tdata[53:6]);
                        failed = 1'b1;
                    end
                    if (m_axis_tdata[69:54] !== e.weight_used)
                    begin
                        $error("weight_used exp %h got %h", e.weight_used, m_axis_tdata[69:54]);
                        failed = 1'b1;
                    end
                    if (m_axis_tdata[70] !== e.weight_explicit)
                    begin
                        $error("weight_explicit exp %b got %b", e.weight_explicit,
                               m_axis_tdata[70]);
                        failed = 1'b1;
                    end
                    if (m_axis_tuser !== e.table_full)
                    begin
                        $error("table_full exp %b got %b", e.table_full, m_axis_tuser);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        idle_cycles = 0;
        failed = 1'b0;
        flow_count = 0;
        for (int i = 0; i < NFLOWS; i++)
            flow_valid[i] = 1'b0;
        // Half the pool are variations of an earlier key in a single field,
        // so the lookup must compare the whole key.
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            if (i > 0 && i % 2 == 1)
            begin
                key_pool[i] = key_pool[i - 1];
                case ($urandom_range(3))
                    0: key_pool[i].src_addr = $urandom;
                    1: key_pool[i].src_port = $urandom;
                    2: key_pool[i].dst_addr = $urandom;
                    default: key_pool[i].dst_port = $urandom;
                endcase
            end
            else
                key_pool[i] = fresh_key();
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        // The sender holds off here until every stamp has come back.
        drain_stamps();
        test_random(250, 0, 0);
        test_random(250, 69, 0);
        drain_stamps();
        test_random(250, 0, 69);
        test_random(250, 38, 38);
        test_table_full();
        drain_stamps();

        repeat (200) @(negedge clk);
        if (!failed && pending_stamps.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/wfq_pkg.sv
rtl/core/wfq_ram.sv
rtl/core/wfq_ctrl.sv
rtl/core/wfq_dp.sv
rtl/core/wfq_finish_tag_stamper.sv
dv/wfq_finish_tag_stamper_tb.sv
